// ===== sv/zeros_to_polynomial_expander_core_defines.svh =====
// Assertion macros shared by the expander RTL.
`ifndef ZEROS_TO_POLYNOMIAL_EXPANDER_CORE_DEFINES_SVH
`define ZEROS_TO_POLYNOMIAL_EXPANDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ZPE_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ZPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ZPE_ASSERT(label, clk, rst_n, ante, cons, msg)
`define ZPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/zpe_pkg.sv =====
// Types and constants of the zeros-to-polynomial expander.
`default_nettype none
package zpe_pkg;

    localparam int COEF_W     = 32;
    localparam int ZERO_W     = 16;
    localparam int COEF_IDX_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int PROD_W     = COEF_W + ZERO_W;
    localparam int ACC_W      = PROD_W + 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IM = 1'd1;

    // gain after reset: 1.0 + 0j in Q16.16
    localparam logic signed [COEF_W-1:0] GAIN_RE_RESET = 32'sd65536;
    localparam logic signed [COEF_W-1:0] GAIN_IM_RESET = 32'sd0;

    typedef struct packed {
        logic signed [ZERO_W-1:0] zero_re;
        logic signed [ZERO_W-1:0] zero_im;
        logic                     first;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic [COEF_IDX_W-1:0]    coef_index;
        logic signed [COEF_W-1:0] coef_re;
        logic signed [COEF_W-1:0] coef_im;
        logic                     overflow;
        logic                     final_res;
    } result_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
    } coef_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] mul_a;
        logic signed [ZERO_W-1:0] mul_b;
        acc_op_t                  op;
        logic signed [COEF_W-1:0] load;
    } mac_ctl_t;

endpackage
`default_nettype wire

// ===== sv/zeros_to_polynomial_expander_core.sv =====
// Top level of the zeros-to-polynomial expander.
//
//  channel   signals                       transfer when
//  item      start, busy, item             start && !busy
//  result    result_valid, result          result_valid (one-cycle strobe)
//  config    cfg_we, cfg_index, cfg_data   cfg_we
//
// A zero on a degree-n polynomial runs on the shared multiplier-accumulator
// (four 32x16 products per coefficient), after the gain is reloaded when
// first is set; a last item then emits every stored coefficient. busy covers
// the whole item; a zero dropped at a full store without last leaves the
// core idle. Reset clears control state, the gain and the result outputs,
// not the store or datapath registers; the receiver cannot stall results.
`default_nettype none
`include "zeros_to_polynomial_expander_core_defines.svh"
module zeros_to_polynomial_expander_core #(
    parameter int MAX_ZEROS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire zpe_pkg::item_t                  item,
    output logic                                 result_valid,
    output zpe_pkg::result_t                     result,
    input  wire logic                            cfg_we,
    input  wire logic [zpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [zpe_pkg::COEF_W-1:0]      cfg_data
);
    import zpe_pkg::*;

    localparam int DEPTH = MAX_ZEROS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] MAX_CNT = AW'(MAX_ZEROS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RD_TOP,
        S_TOP,
        S_MAC,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    typedef enum logic [2:0] {
        P_MUL_RR,
        P_MUL_II,
        P_MUL_RI,
        P_MUL_IR,
        P_ACC_IM,
        P_WRITE
    } phase_t;

    state_t  state_reg;
    phase_t  ph_reg;
    logic [AW-1:0] count_reg;
    logic [AW-1:0] j_reg;
    logic [AW-1:0] k_reg;
    logic          ovf_reg;
    logic          last_reg;
    logic signed [COEF_W-1:0] gain_re_reg;
    logic signed [COEF_W-1:0] gain_im_reg;

    logic signed [ZERO_W-1:0] zr_reg;
    logic signed [ZERO_W-1:0] zi_reg;
    coef_t                    a_reg;
    coef_t                    b_reg;
    logic signed [COEF_W-1:0] res_re_reg;

    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    coef_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    coef_t         ram_rdata;
    mac_ctl_t      mac_ctl;
    logic signed [COEF_W-1:0] mac_res;
    logic          mac_sat;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    zpe_ram #(
        .WIDTH ($bits(coef_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    zpe_mac u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .result (mac_res),
        .sat    (mac_sat)
    );

    // store port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = a_reg;
        ram_raddr = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{re: gain_re_reg, im: gain_im_reg};
            end
            S_RD_TOP:
            begin
                ram_raddr = count_reg;
            end
            S_TOP:
            begin
                // top coefficient moves up one degree unchanged
                ram_we    = 1'b1;
                ram_waddr = count_reg + AW'(1);
                ram_wdata = ram_rdata;
            end
            S_MAC:
            begin
                ram_raddr = (j_reg == '0) ? '0 : j_reg - AW'(1);
                if (ph_reg == P_WRITE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = '{re: res_re_reg, im: mac_res};
                end
            end
            S_EMIT_RD:
            begin
                ram_raddr = k_reg;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // multiplier schedule: re = b.re + a.re*zr - a.im*zi, im = b.im + a.re*zi + a.im*zr
    always_comb
    begin
        mac_ctl = '{mul_a: a_reg.re, mul_b: zr_reg, op: ACC_HOLD, load: '0};
        if (state_reg == S_MAC)
        begin
            unique case (ph_reg)
                P_MUL_RR:
                begin
                    mac_ctl.mul_a = a_reg.re;
                    mac_ctl.mul_b = zr_reg;
                end
                P_MUL_II:
                begin
                    mac_ctl.mul_a = a_reg.im;
                    mac_ctl.mul_b = zi_reg;
                    mac_ctl.op    = ACC_LOAD;
                    mac_ctl.load  = (j_reg == '0) ? '0 : ram_rdata.re;
                end
                P_MUL_RI:
                begin
                    mac_ctl.mul_a = a_reg.re;
                    mac_ctl.mul_b = zi_reg;
                    mac_ctl.op    = ACC_SUB;
                end
                P_MUL_IR:
                begin
                    mac_ctl.mul_a = a_reg.im;
                    mac_ctl.mul_b = zr_reg;
                    mac_ctl.op    = ACC_LOAD;
                    mac_ctl.load  = b_reg.im;
                end
                P_ACC_IM:
                begin
                    mac_ctl.op = ACC_ADD;
                end
                P_WRITE:
                begin
                    mac_ctl.op = ACC_HOLD;
                end
                default:
                begin
                    mac_ctl.op = ACC_HOLD;
                end
            endcase
        end
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zr_reg <= item.zero_re;
            zi_reg <= item.zero_im;
        end
        if (state_reg == S_TOP)
        begin
            a_reg <= ram_rdata;
        end
        if (state_reg == S_MAC)
        begin
            if (ph_reg == P_MUL_II)
            begin
                b_reg <= (j_reg == '0) ? '0 : ram_rdata;
            end
            if (ph_reg == P_MUL_IR)
            begin
                res_re_reg <= mac_res;
            end
            if (ph_reg == P_WRITE)
            begin
                a_reg <= b_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ph_reg       <= P_MUL_RR;
            count_reg    <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            ovf_reg      <= 1'b0;
            last_reg     <= 1'b0;
            gain_re_reg  <= GAIN_RE_RESET;
            gain_im_reg  <= GAIN_IM_RESET;
            result_valid <= 1'b0;
            result       <= '0;
        end
        else
        begin
            result_valid <= (state_reg == S_EMIT_OUT);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GAIN_RE: gain_re_reg <= cfg_data;
                    REG_GAIN_IM: gain_im_reg <= cfg_data;
                    default:     gain_re_reg <= gain_re_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= item.last;
                        k_reg    <= '0;
                        if (item.first)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else if (count_reg == MAX_CNT)
                        begin
                            // store full: zero dropped
                            ovf_reg   <= 1'b1;
                            state_reg <= item.last ? S_EMIT_RD : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_RD_TOP;
                        end
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_RD_TOP;
                end
                S_RD_TOP:
                begin
                    state_reg <= S_TOP;
                end
                S_TOP:
                begin
                    j_reg     <= count_reg;
                    ph_reg    <= P_MUL_RR;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    unique case (ph_reg)
                        P_MUL_RR: ph_reg <= P_MUL_II;
                        P_MUL_II: ph_reg <= P_MUL_RI;
                        P_MUL_RI: ph_reg <= P_MUL_IR;
                        P_MUL_IR:
                        begin
                            ovf_reg <= ovf_reg | mac_sat;
                            ph_reg  <= P_ACC_IM;
                        end
                        P_ACC_IM: ph_reg <= P_WRITE;
                        P_WRITE:
                        begin
                            ovf_reg <= ovf_reg | mac_sat;
                            ph_reg  <= P_MUL_RR;
                            if (j_reg == '0)
                            begin
                                count_reg <= count_reg + AW'(1);
                                state_reg <= last_reg ? S_EMIT_RD : S_IDLE;
                            end
                            else
                            begin
                                j_reg <= j_reg - AW'(1);
                            end
                        end
                        default: ph_reg <= P_MUL_RR;
                    endcase
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_OUT;
                end
                S_EMIT_OUT:
                begin
                    result.coef_index <= COEF_IDX_W'(k_reg);
                    result.coef_re    <= ram_rdata.re;
                    result.coef_im    <= ram_rdata.im;
                    result.overflow   <= ovf_reg;
                    result.final_res  <= (k_reg == count_reg);
                    if (k_reg == count_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= S_EMIT_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a dropped zero without last never leaves idle
    `ZPE_ASSERT_NEXT(a_accept_busy, clk, rst_n,
        accept && (item.first || item.last || (count_reg != MAX_CNT)), busy,
        "item transfer did not raise busy")
    `ZPE_ASSERT_NEXT(a_final_ends, clk, rst_n, result_valid && result.final_res, !result_valid, "result after final coefficient")
    `ZPE_ASSERT(a_emit_cadence, clk, rst_n, result_valid && !result.final_res, ##2 result_valid, "coefficient stream broke before final")
    `ZPE_ASSERT(a_mac_room, clk, rst_n, state_reg == S_MAC, count_reg < MAX_CNT, "zero applied to a full store")

endmodule
`default_nettype wire

// ===== sv/zpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module zpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 17
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/zpe_mac.sv =====
// Shared 32x16 multiplier, accumulator and Q.24 to Q16.16 round/saturate.
`default_nettype none
module zpe_mac (
    input  wire logic                            clk,
    input  wire zpe_pkg::mac_ctl_t               ctl,
    output logic signed [zpe_pkg::COEF_W-1:0]    result,
    output logic                                 sat
);
    import zpe_pkg::*;

    localparam int RND_W = ACC_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  load_ext;
    logic signed [RND_W-1:0]  rounded;
    logic signed [RND_W-1:0]  shifted;

    assign prod_ext = ACC_W'(prod_reg);
    assign load_ext = ACC_W'(ctl.load) <<< 8;

    always_ff @(posedge clk)
    begin
        prod_reg <= ctl.mul_a * ctl.mul_b;
        unique case (ctl.op)
            ACC_HOLD: acc_reg <= acc_reg;
            ACC_LOAD: acc_reg <= load_ext + prod_ext;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            ACC_SUB:  acc_reg <= acc_reg - prod_ext;
            default:  acc_reg <= acc_reg;
        endcase
    end

    // add half LSB, floor shift; saturate if the top bits disagree
    always_comb
    begin
        rounded = RND_W'(acc_reg) + RND_W'(128);
        shifted = rounded >>> 8;
        sat     = !((&shifted[RND_W-1:COEF_W-1]) || !(|shifted[RND_W-1:COEF_W-1]));
        if (sat)
        begin
            result = shifted[RND_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                      : {1'b0, {(COEF_W-1){1'b1}}};
        end
        else
        begin
            result = shifted[COEF_W-1:0];
        end
    end

endmodule
`default_nettype wire
